[rtl/core/ngga_pkg.sv]
// ---------------------------------------------------------------------------
// ngga_pkg
// Shared types and constants of the GGA sentence parser: character codes,
// field numbers, limits and the stored fix record.
// ---------------------------------------------------------------------------
`default_nettype none

package ngga_pkg;

	// characters
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_A     = 8'h41;

	// field numbers: count of commas seen on the line
	localparam logic [3:0] F_NONE = 4'd0;
	localparam logic [3:0] F_TIME = 4'd1;
	localparam logic [3:0] F_LAT  = 4'd2;
	localparam logic [3:0] F_NS   = 4'd3;
	localparam logic [3:0] F_LON  = 4'd4;
	localparam logic [3:0] F_EW   = 4'd5;
	localparam logic [3:0] F_QUAL = 4'd6;
	localparam logic [3:0] F_SATS = 4'd7;
	localparam logic [3:0] F_HDOP = 4'd8;
	localparam logic [3:0] F_ALT  = 4'd9;
	localparam logic [3:0] F_UNIT = 4'd10;
	localparam logic [3:0] F_DONE = 4'd11;

	// line flag bits
	localparam logic [3:0] FLAGS_LINE  = 4'hE;
	localparam logic [3:0] KEEP_NO_TIM = 4'hD;
	localparam logic [3:0] KEEP_NO_POS = 4'hB;
	localparam logic [3:0] KEEP_NO_ALT = 4'h7;

	// field lengths
	localparam logic [4:0] MAX_FIELD_CHARS = 5'd15;
	localparam logic [4:0] FLEN_MAX        = 5'd31;
	localparam logic [4:0] LEN_TIME        = 5'd8;
	localparam logic [4:0] LEN_LAT         = 5'd9;
	localparam logic [4:0] LEN_LON         = 5'd10;
	localparam logic [4:0] LEN_CHAR        = 5'd1;
	localparam logic [2:0] CPOS_MAX        = 3'd7;
	localparam logic [2:0] CPOS_ID_DONE    = 3'd6;

	// arithmetic limits
	localparam logic [39:0] ACC_CAP       = 40'd100_000_000_000;
	localparam logic [39:0] ALT_OVF_X100  = 40'd20_000_000;
	localparam logic [39:0] ALT_OVF_X10   = 40'd200_000_000;
	localparam logic [39:0] ALT_OVF_X1    = 40'd2_000_000_000;
	localparam logic [31:0] ALT_LIMIT     = 32'd2_000_000_000;
	localparam logic [29:0] LAT_LIMIT     = 30'd999_999_999;
	localparam logic [33:0] DEG_SCALE     = 34'd10_000_000;
	// (2^27 + 1) / 3, exact floor(x/3) for x below 2^27
	localparam logic [26:0] DIV3_MUL      = 27'd44_739_243;

	typedef struct packed {
		logic [3:0]         flags;
		logic [6:0]         hour;
		logic [6:0]         minute;
		logic [6:0]         second;
		logic [29:0]        lat;
		logic [7:0]         lat_hemi;
		logic [33:0]        lon;
		logic [7:0]         lon_hemi;
		logic [7:0]         sats;
		logic signed [31:0] alt;
		logic [7:0]         unit;
	} fix_t;

endpackage

`default_nettype wire

[rtl/core/ngga_byte_if.sv]
// ---------------------------------------------------------------------------
// ngga_byte_if
// Valid/ready channel carrying one received character per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface ngga_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[rtl/core/ngga_fix_if.sv]
// ---------------------------------------------------------------------------
// ngga_fix_if
// Valid/ready channel carrying one decoded GGA fix per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface ngga_fix_if;
	logic               valid;
	logic               ready;
	logic [3:0]         valid_flags;
	logic [6:0]         hour;
	logic [6:0]         minute;
	logic [6:0]         second;
	logic [29:0]        latitude_e7;
	logic [7:0]         lat_hemisphere;
	logic [33:0]        longitude_e7;
	logic [7:0]         lon_hemisphere;
	logic [7:0]         satellites;
	logic signed [31:0] altitude_cm;
	logic [7:0]         alt_unit;

	modport source (
		output valid, input ready,
		output valid_flags, output hour, output minute, output second,
		output latitude_e7, output lat_hemisphere, output longitude_e7,
		output lon_hemisphere, output satellites, output altitude_cm,
		output alt_unit
	);
	modport sink (
		input valid, output ready,
		input valid_flags, input hour, input minute, input second,
		input latitude_e7, input lat_hemisphere, input longitude_e7,
		input lon_hemisphere, input satellites, input altitude_cm,
		input alt_unit
	);
endinterface

`default_nettype wire

[rtl/core/ngga_angle.sv]
// ---------------------------------------------------------------------------
// ngga_angle
// Converts whole degrees plus six minute digits (mm.mmmm as an integer)
// into 1e-7 degree units: deg * 1e7 + floor(minutes * 50 / 3).
// ---------------------------------------------------------------------------
`default_nettype none

module ngga_angle
	import ngga_pkg::*;
(
	input  logic [9:0]  deg,
	input  logic [19:0] min_digits,
	output logic [33:0] angle
);

	logic [33:0] deg_part;
	logic [20:0] two_min;
	logic [47:0] div3_prod;

	// 50/3 = 16 + 2/3, so only 2*m needs the divide by three
	assign deg_part  = {24'b0, deg} * DEG_SCALE;
	assign two_min   = {min_digits, 1'b0};
	assign div3_prod = {27'b0, two_min} * {21'b0, DIV3_MUL};

	assign angle = deg_part + {10'b0, min_digits, 4'b0} + {13'b0, div3_prod[47:27]};

endmodule

`default_nettype wire

[rtl/core/nmea_gga_sentence_parser_core.sv]
// ---------------------------------------------------------------------------
// nmea_gga_sentence_parser_core
// Streaming NMEA 0183 GGA decoder, one character per beat.
// ---------------------------------------------------------------------------
// rx carries received characters; every line ends at a newline (0x0A).
// Lines whose id bytes 3..5 read GGA have their comma fields decoded into a
// stored fix as each field closes. At the newline of such a line one beat
// leaves on fix with the stored fix and the line's flags; other lines give
// no beat.
// A character is registered on acceptance and decoded from the input register;
// the newline's decode loads the output register, which raises fix.valid.
// Throughput is one character per cycle unless fix stalls, set by the single
// decode stage. When fix is stalled a pending result stays in the output
// register; only a second newline that would emit is held in the input
// register, which drops rx.ready until the output frees.
// Reset clears the line state, the stored fix and both valid bits.
// ---------------------------------------------------------------------------
`default_nettype none

module nmea_gga_sentence_parser_core
	import ngga_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	ngga_byte_if.sink  rx,
	ngga_fix_if.source fix
);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// line and field state
	logic [2:0]  char_pos_q, char_pos_d;
	logic        is_gga_q, is_gga_d;
	logic [3:0]  field_num_q, field_num_d;
	logic [4:0]  field_len_q, field_len_d;
	logic [39:0] acc_q, acc_d;
	logic [1:0]  frac_q, frac_d;
	logic        neg_q, neg_d;
	logic [9:0]  deg_q, deg_d;
	logic [3:0]  line_flags_q, line_flags_d;
	logic [6:0]  t_hh_q, t_hh_d;
	logic [6:0]  t_mm_q, t_mm_d;
	logic [6:0]  t_ss_q, t_ss_d;
	fix_t        fix_q, fix_d;

	// output register
	logic       out_valid_q;
	fix_t       out_q;
	fix_t       out_d;

	logic        line_ok, emit, out_free, step;
	logic        is_digit, collecting;
	logic [3:0]  digit;
	logic [39:0] acc_push;
	logic [33:0] angle;
	logic [29:0] lat_sat;
	logic        alt_ovf;
	logic [31:0] alt_mag;
	logic [3:0]  out_flags;

	ngga_angle u_angle (
		.deg        (deg_q),
		.min_digits (acc_q[19:0]),
		.angle      (angle)
	);

	assign line_ok  = is_gga_q && (char_pos_q >= CPOS_ID_DONE);
	assign emit     = (byte_s1 == CH_LF) && line_ok;
	assign out_free = !out_valid_q || fix.ready;
	assign step     = valid_s1 && (!emit || out_free);
	assign rx.ready = !valid_s1 || !emit || out_free;

	assign is_digit = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
	assign digit    = is_digit ? byte_s1[3:0] : 4'd0;
	assign acc_push = (acc_q < ACC_CAP) ? (acc_q << 3) + (acc_q << 1) + {36'b0, digit} : acc_q;
	assign lat_sat  = (angle > {4'b0, LAT_LIMIT}) ? LAT_LIMIT : angle[29:0];
	assign collecting = (field_num_q >= F_TIME) && (field_num_q <= F_UNIT);

	// altitude scaling by the number of decimals seen
	always_comb begin
		if (frac_q <= 2'd1) begin
			alt_ovf = acc_q > ALT_OVF_X100;
			alt_mag = acc_q[31:0] * 32'd100;
		end else if (frac_q == 2'd2) begin
			alt_ovf = acc_q > ALT_OVF_X10;
			alt_mag = acc_q[31:0] * 32'd10;
		end else begin
			alt_ovf = acc_q > ALT_OVF_X1;
			alt_mag = acc_q[31:0];
		end
		if (alt_ovf) begin
			alt_mag = ALT_LIMIT;
		end
	end

	always_comb begin
		char_pos_d   = char_pos_q;
		is_gga_d     = is_gga_q;
		field_num_d  = field_num_q;
		field_len_d  = field_len_q;
		acc_d        = acc_q;
		frac_d       = frac_q;
		neg_d        = neg_q;
		deg_d        = deg_q;
		line_flags_d = line_flags_q;
		t_hh_d       = t_hh_q;
		t_mm_d       = t_mm_q;
		t_ss_d       = t_ss_q;
		fix_d        = fix_q;

		if (byte_s1 == CH_LF) begin
			if (line_ok && field_num_q != F_NONE) begin
				fix_d.flags = line_flags_q & FLAGS_LINE;
			end
			char_pos_d   = '0;
			is_gga_d     = 1'b0;
			field_num_d  = F_NONE;
			line_flags_d = '0;
			field_len_d  = '0;
			acc_d        = '0;
			frac_d       = '0;
			neg_d        = 1'b0;
			deg_d        = '0;
			t_hh_d       = '0;
			t_mm_d       = '0;
			t_ss_d       = '0;
		end else begin
			if (byte_s1 == CH_COMMA) begin
				// close the current field
				case (field_num_q)
					F_NONE: begin
						line_flags_d = FLAGS_LINE;
					end
					F_TIME: begin
						if (field_len_q != LEN_TIME) begin
							line_flags_d = line_flags_q & KEEP_NO_TIM;
						end else if (line_ok) begin
							fix_d.hour   = t_hh_q;
							fix_d.minute = t_mm_q;
							fix_d.second = t_ss_q;
						end
					end
					F_LAT: begin
						if (field_len_q != LEN_LAT) begin
							line_flags_d = line_flags_q & KEEP_NO_POS;
						end else if (line_ok) begin
							fix_d.lat = lat_sat;
						end
					end
					F_NS: begin
						if (field_len_q != LEN_CHAR) begin
							line_flags_d = line_flags_q & KEEP_NO_POS;
						end else if (line_ok) begin
							fix_d.lat_hemi = acc_q[7:0];
						end
					end
					F_LON: begin
						if (field_len_q != LEN_LON) begin
							line_flags_d = line_flags_q & KEEP_NO_POS;
						end else if (line_ok) begin
							fix_d.lon = angle;
						end
					end
					F_EW: begin
						if (field_len_q != LEN_CHAR) begin
							line_flags_d = line_flags_q & KEEP_NO_POS;
						end else if (line_ok) begin
							fix_d.lon_hemi = acc_q[7:0];
						end
					end
					F_SATS: begin
						if (field_len_q <= MAX_FIELD_CHARS && line_ok) begin
							fix_d.sats = (|acc_q[39:8]) ? 8'hFF : acc_q[7:0];
						end
					end
					F_ALT: begin
						if (field_len_q <= MAX_FIELD_CHARS && line_ok) begin
							fix_d.alt = neg_q ? -$signed(alt_mag) : $signed(alt_mag);
						end
					end
					F_UNIT: begin
						if (field_len_q != LEN_CHAR) begin
							line_flags_d = line_flags_q & KEEP_NO_ALT;
						end else if (line_ok) begin
							fix_d.unit = acc_q[7:0];
						end
					end
					default: begin
					end
				endcase
				if (field_num_q < F_DONE) begin
					field_num_d = field_num_q + 4'd1;
				end
				field_len_d = '0;
				acc_d       = '0;
				frac_d      = '0;
				neg_d       = 1'b0;
				deg_d       = '0;
				t_hh_d      = '0;
				t_mm_d      = '0;
				t_ss_d      = '0;
			end else if (collecting) begin
				case (field_num_q)
					F_TIME: begin
						if (field_len_q < 5'd2) begin
							t_hh_d = t_hh_q * 7'd10 + {3'b0, digit};
						end else if (field_len_q < 5'd4) begin
							t_mm_d = t_mm_q * 7'd10 + {3'b0, digit};
						end else if (field_len_q < 5'd6) begin
							t_ss_d = t_ss_q * 7'd10 + {3'b0, digit};
						end
					end
					F_LAT: begin
						if (field_len_q < 5'd2) begin
							deg_d = deg_q * 10'd10 + {6'b0, digit};
						end else if (field_len_q != 5'd4 && field_len_q < 5'd9) begin
							acc_d = acc_push;
						end
					end
					F_LON: begin
						if (field_len_q < 5'd3) begin
							deg_d = deg_q * 10'd10 + {6'b0, digit};
						end else if (field_len_q != 5'd5 && field_len_q < 5'd10) begin
							acc_d = acc_push;
						end
					end
					F_NS, F_EW, F_UNIT: begin
						if (field_len_q == '0) begin
							acc_d = {32'b0, byte_s1};
						end
					end
					F_SATS: begin
						acc_d = acc_push;
					end
					F_ALT: begin
						// sign only in first place, first dot opens the decimals
						if (field_len_q == '0 && byte_s1 == CH_MINUS) begin
							neg_d = 1'b1;
						end else if (byte_s1 == CH_DOT && frac_q == 2'd0) begin
							frac_d = 2'd1;
						end else if (frac_q == 2'd0) begin
							acc_d = acc_push;
						end else if (frac_q < 2'd3) begin
							acc_d  = acc_push;
							frac_d = frac_q + 2'd1;
						end
					end
					default: begin
					end
				endcase
				if (field_len_q < FLEN_MAX) begin
					field_len_d = field_len_q + 5'd1;
				end
			end

			// id check on bytes 3..5
			case (char_pos_q)
				3'd3: is_gga_d = (byte_s1 == CH_G);
				3'd4: is_gga_d = is_gga_q && (byte_s1 == CH_G);
				3'd5: is_gga_d = is_gga_q && (byte_s1 == CH_A);
				default: is_gga_d = is_gga_q;
			endcase
			if (char_pos_q < CPOS_MAX) begin
				char_pos_d = char_pos_q + 3'd1;
			end
		end
	end

	assign out_flags = fix_d.flags | {3'b0, field_num_q >= F_DONE};

	always_comb begin
		out_d       = fix_d;
		out_d.flags = out_flags;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_pos_q   <= '0;
			is_gga_q     <= 1'b0;
			field_num_q  <= F_NONE;
			field_len_q  <= '0;
			acc_q        <= '0;
			frac_q       <= '0;
			neg_q        <= 1'b0;
			deg_q        <= '0;
			line_flags_q <= '0;
			t_hh_q       <= '0;
			t_mm_q       <= '0;
			t_ss_q       <= '0;
			fix_q        <= '0;
		end else if (step) begin
			char_pos_q   <= char_pos_d;
			is_gga_q     <= is_gga_d;
			field_num_q  <= field_num_d;
			field_len_q  <= field_len_d;
			acc_q        <= acc_d;
			frac_q       <= frac_d;
			neg_q        <= neg_d;
			deg_q        <= deg_d;
			line_flags_q <= line_flags_d;
			t_hh_q       <= t_hh_d;
			t_mm_q       <= t_mm_d;
			t_ss_q       <= t_ss_d;
			fix_q        <= fix_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && emit) begin
			out_valid_q <= 1'b1;
		end else if (fix.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			out_q <= out_d;
		end
	end

	assign fix.valid          = out_valid_q;
	assign fix.valid_flags    = out_q.flags;
	assign fix.hour           = out_q.hour;
	assign fix.minute         = out_q.minute;
	assign fix.second         = out_q.second;
	assign fix.latitude_e7    = out_q.lat;
	assign fix.lat_hemisphere = out_q.lat_hemi;
	assign fix.longitude_e7   = out_q.lon;
	assign fix.lon_hemisphere = out_q.lon_hemi;
	assign fix.satellites     = out_q.sats;
	assign fix.altitude_cm    = out_q.alt;
	assign fix.alt_unit       = out_q.unit;

endmodule

`default_nettype wire

[rtl/core/ngga_checker.sv]
// ---------------------------------------------------------------------------
// ngga_checker
// Port-level checks of the GGA parser, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module ngga_checker
	import ngga_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               rx_valid,
	input logic               rx_ready,
	input logic [7:0]         rx_byte,
	input logic               fix_valid,
	input logic               fix_ready,
	input logic [3:0]         fix_flags,
	input logic [6:0]         fix_hour,
	input logic [29:0]        fix_lat,
	input logic [33:0]        fix_lon,
	input logic signed [31:0] fix_alt
);

	// a stalled result beat holds
	a_fix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fix_valid && !fix_ready |=> fix_valid && $stable(fix_flags) && $stable(fix_hour)
			&& $stable(fix_lat) && $stable(fix_lon) && $stable(fix_alt))
		else $error("fix beat changed while stalled");

	// a fresh result must follow a newline beat accepted on rx
	a_fix_after_lf: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fix_valid) |-> $past(rx_valid && rx_ready && rx_byte == CH_LF, 2))
		else $error("fix beat without a newline beat two cycles earlier");

	// input only backs up behind a stalled result
	a_rx_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!rx_ready |-> fix_valid && !fix_ready)
		else $error("rx stalled while fix is free");

endmodule

bind nmea_gga_sentence_parser_core ngga_checker u_ngga_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rx_valid  (rx.valid),
	.rx_ready  (rx.ready),
	.rx_byte   (rx.rx_byte),
	.fix_valid (fix.valid),
	.fix_ready (fix.ready),
	.fix_flags (fix.valid_flags),
	.fix_hour  (fix.hour),
	.fix_lat   (fix.latitude_e7),
	.fix_lon   (fix.longitude_e7),
	.fix_alt   (fix.altitude_cm)
);

`default_nettype wire

[tb/tb_nmea_gga_sentence_parser_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_nmea_gga_sentence_parser_core
// Streams NMEA text into the GGA parser one character per beat and checks
// every decoded fix against a cycle-free model of the line decoder kept in
// this bench. Directed sentences cover extreme and malformed fields, then
// random sentences, near-miss ids, short lines and byte noise follow, with
// random gaps on rx and random stalls on fix.
// ---------------------------------------------------------------------------

module tb_nmea_gga_sentence_parser_core
	import ngga_pkg::*;
();

	typedef struct packed {
		logic [7:0] ch;
		logic       drain;
	} char_beat_t;

	logic clk;
	logic arst_n;

	ngga_byte_if rx_if ();
	ngga_fix_if  fix_if ();

	nmea_gga_sentence_parser_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.fix    (fix_if)
	);

	char_beat_t rx_chars[$];
	fix_t       due_fixes[$];
	int         chars_total;
	int         chars_accepted = 0;
	int         gga_made = 0;
	int         mismatches = 0;
	int         gap_left;
	int         stall_left;
	int         rx_calm = 0;
	int         fix_calm = 0;

	// line decoder state
	logic [2:0]      line_pos = '0;
	logic            gga_id = 1'b0;
	logic [3:0]      comma_cnt = F_NONE;
	logic [4:0]      fld_len = '0;
	longint unsigned num_acc = 0;
	logic [1:0]      frac_cnt = '0;
	logic            alt_neg = 1'b0;
	longint unsigned deg_acc = 0;
	logic [3:0]      line_flag_bits = '0;
	fix_t            held_fix = '0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#5000000;
		$display("FAIL");
		$finish;
	end

	// ---------------- line decoder ----------------

	task automatic clear_field();
		fld_len = '0;
		num_acc = 0;
		frac_cnt = '0;
		alt_neg = 1'b0;
		deg_acc = 0;
	endtask

	task automatic push_digit(input logic [3:0] d);
		if (num_acc < ACC_CAP)
			num_acc = num_acc * 10 + d;
	endtask

	task automatic take_char(input logic [7:0] c);
		logic [3:0] d;
		d = (c >= CH_ZERO && c <= CH_NINE) ? 4'(c - CH_ZERO) : 4'd0;
		case (comma_cnt)
			F_TIME: begin
				if (fld_len < 6) push_digit(d);
			end
			F_LAT: begin
				if (fld_len < 2) deg_acc = deg_acc * 10 + d;
				else if (fld_len != 4 && fld_len < 9) push_digit(d);
			end
			F_LON: begin
				if (fld_len < 3) deg_acc = deg_acc * 10 + d;
				else if (fld_len != 5 && fld_len < 10) push_digit(d);
			end
			F_NS, F_EW, F_UNIT: begin
				if (fld_len == 0) num_acc = c;
			end
			F_SATS: push_digit(d);
			F_ALT: begin
				if (fld_len == 0 && c == CH_MINUS) alt_neg = 1'b1;
				else if (c == CH_DOT && frac_cnt == 0) frac_cnt = 2'd1;
				else if (frac_cnt == 0) push_digit(d);
				else if (frac_cnt < 3) begin
					push_digit(d);
					frac_cnt++;
				end
			end
			default: ;
		endcase
		if (fld_len < FLEN_MAX) fld_len++;
	endtask

	task automatic close_field(input logic allowed);
		longint unsigned v;
		v = deg_acc * 64'd10_000_000 + num_acc * 50 / 3;
		case (comma_cnt)
			F_TIME: begin
				if (fld_len != LEN_TIME) line_flag_bits &= KEEP_NO_TIM;
				else if (allowed) begin
					held_fix.hour = 7'(num_acc / 10000);
					held_fix.minute = 7'(num_acc / 100 % 100);
					held_fix.second = 7'(num_acc % 100);
				end
			end
			F_LAT: begin
				if (fld_len != LEN_LAT) line_flag_bits &= KEEP_NO_POS;
				else if (allowed) held_fix.lat = (v > LAT_LIMIT) ? LAT_LIMIT : 30'(v);
			end
			F_NS: begin
				if (fld_len != LEN_CHAR) line_flag_bits &= KEEP_NO_POS;
				else if (allowed) held_fix.lat_hemi = 8'(num_acc);
			end
			F_LON: begin
				if (fld_len != LEN_LON) line_flag_bits &= KEEP_NO_POS;
				else if (allowed) held_fix.lon = 34'(v);
			end
			F_EW: begin
				if (fld_len != LEN_CHAR) line_flag_bits &= KEEP_NO_POS;
				else if (allowed) held_fix.lon_hemi = 8'(num_acc);
			end
			F_SATS: begin
				if (fld_len <= MAX_FIELD_CHARS && allowed)
					held_fix.sats = (num_acc > 255) ? 8'hFF : 8'(num_acc);
			end
			F_ALT: begin
				if (fld_len <= MAX_FIELD_CHARS && allowed) begin
					v = num_acc;
					if (frac_cnt <= 1) v = v * 100;
					else if (frac_cnt == 2) v = v * 10;
					if (v > ALT_LIMIT) v = ALT_LIMIT;
					held_fix.alt = alt_neg ? -32'(v) : 32'(v);
				end
			end
			F_UNIT: begin
				if (fld_len != LEN_CHAR) line_flag_bits &= KEEP_NO_ALT;
				else if (allowed) held_fix.unit = 8'(num_acc);
			end
			default: ;
		endcase
	endtask

	task automatic decode_char(input logic [7:0] c);
		logic allowed;
		fix_t out_fix;
		allowed = gga_id && line_pos >= CPOS_ID_DONE;
		if (c == CH_LF) begin
			if (allowed) begin
				if (comma_cnt != F_NONE) held_fix.flags = line_flag_bits & FLAGS_LINE;
				out_fix = held_fix;
				out_fix.flags = (held_fix.flags & FLAGS_LINE) | {3'b000, comma_cnt >= F_DONE};
				due_fixes.push_back(out_fix);
			end
			line_pos = '0;
			gga_id = 1'b0;
			comma_cnt = F_NONE;
			line_flag_bits = '0;
			clear_field();
		end else begin
			if (c == CH_COMMA) begin
				if (comma_cnt == F_NONE) line_flag_bits = FLAGS_LINE;
				else if (comma_cnt <= F_UNIT) close_field(allowed);
				if (comma_cnt < F_DONE) comma_cnt++;
				clear_field();
			end else if (comma_cnt >= F_TIME && comma_cnt <= F_UNIT) begin
				take_char(c);
			end
			// id sits at bytes 3..5
			if (line_pos == 3'd3) gga_id = (c == CH_G);
			else if (line_pos == 3'd4) gga_id = gga_id && (c == CH_G);
			else if (line_pos == 3'd5) gga_id = gga_id && (c == CH_A);
			if (line_pos < CPOS_MAX) line_pos++;
		end
	endtask

	// ---------------- stimulus helpers ----------------

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 72) return 0;
		if (r < 96) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic add_char(input logic [7:0] c, input logic drain = 1'b0);
		char_beat_t b;
		b.ch = c;
		b.drain = drain;
		rx_chars.push_back(b);
	endtask

	task automatic add_text(input string s, input logic drain = 1'b0);
		for (int i = 0; i < s.len(); i++)
			add_char(s[i], drain && i == 0);
	endtask

	function automatic string digits(input int n);
		string s;
		s = "";
		for (int i = 0; i < n; i++)
			s = {s, $sformatf("%0d", $urandom_range(0, 9))};
		return s;
	endfunction

	function automatic string junk_char();
		logic [7:0] c;
		c = CH_COMMA;
		while (c == CH_COMMA)
			c = 8'($urandom_range(33, 126));
		return $sformatf("%c", c);
	endfunction

	// occasionally replace one character with a random printable non-comma character
	function automatic string garble(input string s);
		string j;
		j = junk_char();
		if (s.len() > 0 && $urandom_range(0, 9) == 0)
			s[$urandom_range(0, s.len() - 1)] = j[0];
		return s;
	endfunction

	function automatic string hemi(input string a, input string b);
		int r;
		r = $urandom_range(0, 99);
		if (r < 44) return a;
		if (r < 88) return b;
		if (r < 92) return "";
		if (r < 96) return {a, b};
		return junk_char();
	endfunction

	task automatic add_sentence(input string id);
		string s, t, alt;
		int r;
		r = $urandom_range(0, 99);
		if (r < 88) s = "$GP";
		else if (r < 95) s = "$GN";
		else if (r < 98) s = {junk_char(), junk_char(), junk_char()};
		else s = ",,,";
		s = {s, id, ","};

		r = $urandom_range(0, 99);
		if (r < 88) t = garble({digits(6), ".", digits(1)});
		else t = digits($urandom_range(0, 11));
		s = {s, t, ","};

		r = $urandom_range(0, 99);
		if (r < 85) t = garble({digits(4), ".", digits(4)});
		else if (r < 90) t = {digits(4), junk_char(), digits(4)};
		else t = digits($urandom_range(0, 12));
		s = {s, t, ",", hemi("N", "S"), ","};

		r = $urandom_range(0, 99);
		if (r < 85) t = garble({digits(5), ".", digits(4)});
		else if (r < 90) t = {digits(5), junk_char(), digits(4)};
		else t = digits($urandom_range(0, 12));
		s = {s, t, ",", hemi("E", "W"), ",", digits($urandom_range(0, 1)), ","};

		r = $urandom_range(0, 99);
		if (r < 80) t = garble(digits($urandom_range(1, 2)));
		else if (r < 92) t = digits(3);
		else if (r < 96) t = "";
		else t = digits($urandom_range(14, 20));
		s = {s, t, ","};

		if ($urandom_range(0, 9) < 7) t = {digits(1), ".", digits(1)};
		else t = digits($urandom_range(0, 3));
		s = {s, t, ","};

		alt = ($urandom_range(0, 4) == 0) ? "-" : "";
		alt = {alt, digits(($urandom_range(0, 9) < 9) ? $urandom_range(0, 5)
			: $urandom_range(6, 12))};
		if ($urandom_range(0, 3) != 0) begin
			alt = {alt, ".", digits($urandom_range(0, 4))};
			if ($urandom_range(0, 15) == 0) alt = {alt, ".", digits(1)};
		end
		if ($urandom_range(0, 19) == 0) alt = {alt, digits($urandom_range(6, 10))};
		s = {s, garble(alt), ",", ($urandom_range(0, 9) < 8) ? "M" : hemi("M", "F")};

		r = $urandom_range(0, 99);
		if (r < 75) s = {s, ",", digits(2), ".", digits(1), ",M,,*", digits(2)};
		else if (r < 88) s = {s, ","};
		else if (r < 94) s = {s, ",,,,,,,"};

		if ($urandom_range(0, 9) == 0)
			s = s.substr(0, $urandom_range(0, s.len() - 1));
		if ($urandom_range(0, 1) == 1) s = {s, "\015"};
		s = {s, "\n"};
		add_text(s, $urandom_range(0, 19) == 0);
		if (id == "GGA") gga_made++;
	endtask

	task automatic add_random_line();
		string ids[6];
		string shorts[5];
		int r;
		ids = '{"GSA", "RMC", "GGB", "GXA", "AGA", "GGa"};
		shorts = '{"GGA", "$G", "$GPGG", "", ",,,,"};
		r = $urandom_range(0, 99);
		if (r < 70) begin
			add_sentence("GGA");
		end else if (r < 78) begin
			r = $urandom_range(0, 2);
			if (r == 0) add_text("$GPGGA\n");
			else if (r == 1) add_text("$GPGGA,\n");
			else add_text({"$GPGGA,", digits(6), ".", digits(1), "\n"});
			gga_made++;
		end else if (r < 88) begin
			add_sentence(ids[$urandom_range(0, 5)]);
		end else if (r < 95) begin
			repeat ($urandom_range(1, 40)) add_char(8'($urandom_range(0, 255)));
			add_char(CH_LF);
		end else begin
			add_text({shorts[$urandom_range(0, 4)], "\n"});
		end
	endtask

	// ---------------- sequence ----------------

	initial begin
		// typical sentence, then all-nines and all-zeros fields
		add_text("$GPGGA,123519.0,4807.0380,N,01131.0000,E,1,08,0.9,545.4,M,46.9,M,,*47\015\n");
		add_text("$GNGGA,99999999,9999.9999,S,99999.9999,W,9,999,9.9,-9999999999.99,M,,,,\n");
		add_text("$GPGGA,00000000,0000.0000,N,00000.0000,E,0,0,,0,M,,\n");
		// non-digits, odd point characters, 0xff and 0x00 as hemisphere bytes
		add_text("$GPGGA,1a:b;c?d,4x07#0380,");
		add_char(8'hFF);
		add_text(",01131X0000,");
		add_char(8'h00);
		add_text(",1,0x9,,12.3.4,M,\n");
		// wrong lengths everywhere, sent only after the pipe has drained
		add_text("$GPGGA,1234567,480.0380,NS,0113.0000,,1,,,,MM,\n", 1'b1);
		add_text("$GPGGA\n");
		add_text("$GPGGA,235959.9\n");
		add_text("$GPGGA,,,,,,,12,,1.5,M,\n");
		add_text("$GPGGA,,,,,,,3,,-.,M,\n");
		add_text("$GPGGA,,,,,,,7,,.5,M,\n");
		add_text("$GPGGA,,,,,,,7,,-1.234,M,\n");
		add_text("$GPGGA,,,,,,,1234567890123456,,1234567890123456,M,\n");
		add_text(",,,GGA,12345678,,\n");
		add_text("GGA\n");
		add_text("$GPGG\n");
		add_text("$GPRMC,123519,A,4807.038,N\n");
		add_text("$GPGGB,1\n");
		while (rx_chars.size() < 1300 || gga_made < 40)
			add_random_line();
		chars_total = rx_chars.size();

		while (chars_accepted < chars_total) @(posedge clk);
		while (due_fixes.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// ---------------- rx driver ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_if.valid <= 1'b0;
			rx_if.rx_byte <= '0;
			gap_left <= 0;
		end else begin
			if (rx_if.valid && rx_if.ready) begin
				decode_char(rx_if.rx_byte);
				chars_accepted++;
			end
			if (!rx_if.valid || rx_if.ready) begin
				if (gap_left > 0) begin
					rx_if.valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (rx_chars.size() > 0 &&
						!(rx_chars[0].drain && due_fixes.size() > 0)) begin
					rx_if.valid <= 1'b1;
					rx_if.rx_byte <= rx_chars[0].ch;
					void'(rx_chars.pop_front());
					if (rx_calm > 0) begin
						rx_calm--;
						gap_left <= 0;
					end else begin
						if ($urandom_range(0, 199) == 0) rx_calm = $urandom_range(40, 160);
						gap_left <= idle_len();
					end
				end else begin
					rx_if.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- fix monitor ----------------

	task automatic check_field(input string name, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_fix();
		fix_t want;
		if (due_fixes.size() == 0) begin
			$error("fix beat with no sentence pending");
			mismatches++;
		end else begin
			want = due_fixes.pop_front();
			check_field("valid_flags", want.flags, fix_if.valid_flags);
			check_field("hour", want.hour, fix_if.hour);
			check_field("minute", want.minute, fix_if.minute);
			check_field("second", want.second, fix_if.second);
			check_field("latitude_e7", want.lat, fix_if.latitude_e7);
			check_field("lat_hemisphere", want.lat_hemi, fix_if.lat_hemisphere);
			check_field("longitude_e7", want.lon, fix_if.longitude_e7);
			check_field("lon_hemisphere", want.lon_hemi, fix_if.lon_hemisphere);
			check_field("satellites", want.sats, fix_if.satellites);
			check_field("altitude_cm", want.alt, fix_if.altitude_cm);
			check_field("alt_unit", want.unit, fix_if.alt_unit);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fix_if.ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (fix_if.valid && fix_if.ready)
				check_fix();
			if (stall_left > 0) begin
				fix_if.ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				fix_if.ready <= 1'b1;
				if (fix_calm > 0) begin
					fix_calm--;
					stall_left <= 0;
				end else begin
					if ($urandom_range(0, 199) == 0) fix_calm = $urandom_range(40, 160);
					stall_left <= idle_len();
				end
			end
		end
	end

endmodule

[filelist.f]
rtl/core/ngga_pkg.sv
rtl/core/ngga_byte_if.sv
rtl/core/ngga_fix_if.sv
rtl/core/ngga_angle.sv
rtl/core/nmea_gga_sentence_parser_core.sv
rtl/core/ngga_checker.sv
tb/tb_nmea_gga_sentence_parser_core.sv
